FILE: design/arw_pkg.sv
// Package for the anti-replay window: sizes, status codes and shared types.
// No dependencies; every other design file imports it.
package arw_pkg;

    // Window width in bits and sequence number width
    localparam int WINDOW_BITS = 64;
    localparam int SEQ_BITS    = 48;
    // Bits needed to index one bit of the window
    localparam int IDX_BITS    = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
    localparam int STATUS_BITS = 2;

    // Distance from the base to the top of the window
    localparam logic [SEQ_BITS-1:0] SPAN     = SEQ_BITS'(WINDOW_BITS - 1);
    localparam logic [SEQ_BITS-1:0] WIN_SIZE = SEQ_BITS'(WINDOW_BITS);

    typedef logic [SEQ_BITS-1:0]    seq_t;
    typedef logic [WINDOW_BITS-1:0] mask_t;
    typedef logic [STATUS_BITS-1:0] status_t;

    // Status codes
    localparam status_t ST_FRESH = 2'd0;
    localparam status_t ST_OLD   = 2'd1;
    localparam status_t ST_DUP   = 2'd2;

    // Outcome of one request: status plus the next window state
    typedef struct packed {
        status_t status;
        logic    update;
        seq_t    base;
        mask_t   mask;
    } arw_step_t;

endpackage

FILE: design/arw_in_if.sv
// Request channel of the anti-replay window: valid/ready plus kind and seq_num.
// Depends on arw_pkg.
interface arw_in_if;
    import arw_pkg::*;

    logic valid;
    logic ready;
    logic kind;
    seq_t seq_num;

    modport source (output valid, output kind, output seq_num, input ready);
    modport sink   (input valid, input kind, input seq_num, output ready);
endinterface

FILE: design/arw_out_if.sv
// Result channel of the anti-replay window: valid/ready plus status.
// Depends on arw_pkg.
interface arw_out_if;
    import arw_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

FILE: design/arw_check.sv
// Classification and window update for one request, purely combinational.
// Depends on arw_pkg.
module arw_check
    import arw_pkg::*;
(
    input  logic      kind,
    input  seq_t      seq_num,
    input  seq_t      base,
    input  mask_t     mask,
    output arw_step_t step
);

    seq_t                offset;
    seq_t                shift;
    logic [IDX_BITS-1:0] bit_idx;
    logic                marked;

    // Distance into the window and the amount the window would slide
    assign offset  = seq_num - base;
    assign shift   = offset - SPAN;
    assign bit_idx = SPAN[IDX_BITS-1:0] - offset[IDX_BITS-1:0];
    assign marked  = mask[bit_idx];

    always_comb
    begin
        step.status = ST_FRESH;
        step.update = 1'b0;
        step.base   = base;
        step.mask   = mask;
        if (seq_num < base)
        begin
            // below the window: too old, never recorded
            step.status = ST_OLD;
        end
        else if (offset > SPAN)
        begin
            // above the top: fresh; a kind-1 request slides the window up to seq_num
            step.status = ST_FRESH;
            if (kind)
            begin
                step.update = 1'b1;
                if (shift >= WIN_SIZE)
                    step.mask = '0;
                else
                    step.mask = mask << shift[IDX_BITS-1:0];
                step.mask[0] = 1'b1;
                step.base    = seq_num - SPAN;
            end
        end
        else
        begin
            // inside the window: check the mark, and set it for a kind-1 request
            step.status = marked ? ST_DUP : ST_FRESH;
            if (kind)
            begin
                step.update       = 1'b1;
                step.mask[bit_idx] = 1'b1;
            end
        end
    end

endmodule

FILE: design/anti_replay_window.sv
// Top level of the anti-replay window: input register, check/update, result register.
// Depends on arw_pkg, arw_in_if, arw_out_if and arw_check.
//
// Sliding anti-replay window over 48-bit sequence numbers with a 64-bit seen
// mask. Each request returns exactly one status (0 fresh, 1 too old,
// 2 duplicate), judged before a kind-1 request is recorded. Throughput is one
// request per cycle while the sink is ready. A request is captured in the
// input register at acceptance and is checked there against the window
// state; when it advances, its status is registered in the result register
// and the window update completes so the next request sees it.
// Both sides stall independently; the result register holds while the sink
// is not ready.
module anti_replay_window
    import arw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    arw_in_if.sink   request,
    arw_out_if.source response
);

    logic      req_valid_reg;
    logic      req_kind_reg;
    seq_t      req_seq_reg;
    logic      rsp_valid_reg;
    status_t   rsp_status_reg;
    seq_t      base_reg;
    mask_t     mask_reg;
    logic      advance;
    arw_step_t step;

    // Pipeline flow control
    assign advance       = req_valid_reg && (!rsp_valid_reg || response.ready);
    assign request.ready = !req_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_valid_reg <= 1'b0;
        else if (request.ready)
            req_valid_reg <= request.valid;
    end

    always_ff @(posedge clk)
    begin
        if (request.ready && request.valid)
        begin
            req_kind_reg <= request.kind;
            req_seq_reg  <= request.seq_num;
        end
    end

    // Classification and next window state
    arw_check u_check (
        .kind    (req_kind_reg),
        .seq_num (req_seq_reg),
        .base    (base_reg),
        .mask    (mask_reg),
        .step    (step)
    );

    // Window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            mask_reg <= '0;
        end
        else if (advance && step.update)
        begin
            base_reg <= step.base;
            mask_reg <= step.mask;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= 1'b1;
        else if (response.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_status_reg <= step.status;
    end

    assign response.valid  = rsp_valid_reg;
    assign response.status = rsp_status_reg;

endmodule
